// File: hdl/itoa_pkg.sv
package itoa_pkg;

  // Decimal path: 32-bit two's complement input, ten BCD digits of magnitude
  localparam int DEC_BITS   = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_BITS   = DEC_DIGITS * 4;

  localparam int HEX_VALUE_WIDTH_DEF = 64;

  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] ALPHA_CHAR = 8'h41;
  localparam logic [3:0] DEC_RADIX  = 4'd10;

  // Map one nibble to its ASCII digit, upper-case for ten and above
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < DEC_RADIX) begin
      ch = ZERO_CHAR + {4'd0, nib};
    end else begin
      ch = ALPHA_CHAR + {4'd0, nib - DEC_RADIX};
    end
    return ch;
  endfunction

endpackage

// File: hdl/itoa_dabble_step.sv
module itoa_dabble_step import itoa_pkg::*; (
  input  logic [BCD_BITS-1:0] bcd_in,
  input  logic                shift_in,
  output logic [BCD_BITS-1:0] bcd_out
);

  logic [BCD_BITS-1:0] adjusted;

  // Add three to every digit of five or more, then shift in the next bit
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd_in[d*4 +: 4] >= 4'd5) begin
        adjusted[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
      end else begin
        adjusted[d*4 +: 4] = bcd_in[d*4 +: 4];
      end
    end
    bcd_out = {adjusted[BCD_BITS-2:0], shift_in};
  end

endmodule

// File: hdl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
//
// Command channel: pulse start with operation and value while busy is low;
// the beat is taken at that edge and busy rises in the next cycle. With
// operation 0 the low 32 bits are printed as a signed decimal number, with
// operation 1 the low HEX_VALUE_WIDTH bits as upper-case hex, both without
// leading zeros. Zero prints as a single '0'.
//
// Result channel: each character is on character for exactly one cycle with
// strobe high; last marks the final character of the number. The receiver
// cannot hold results off, so it must take every strobed beat.
//
// Sequence: hex runs straight to the emit phase, which steps through the nibble
// positions from the top (leading zeros are skipped silently). Decimal shifts
// the magnitude bit by bit through the shared BCD step unit (shift-add-3), then
// takes an optional sign beat, then emits the ten digit positions.
// busy falls in the cycle that carries the last character, so the next
// command can be taken at the edge that ends it.
//
// Reset clears the sequencer and strobe; any run in progress is dropped.
module integer_to_ascii_formatter import itoa_pkg::*; #(
  parameter int HEX_VALUE_WIDTH = HEX_VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] value,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);

  localparam int HEX_NIBBLES = (HEX_VALUE_WIDTH + 3) / 4;
  localparam int NIBBLES     = (HEX_NIBBLES > DEC_DIGITS) ? HEX_NIBBLES : DEC_DIGITS;
  localparam int DIG_BITS    = NIBBLES * 4;
  localparam int IDX_W       = $clog2(NIBBLES);
  localparam int CNT_W       = $clog2(DEC_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state;
  logic                neg;
  logic                started;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    idx;
  logic [DEC_BITS-1:0] mag;
  logic [DIG_BITS-1:0] digits;

  logic [DIG_BITS-1:0] hex_load;
  logic [DIG_BITS-1:0] digits_next;
  logic [BCD_BITS-1:0] step_out;
  logic [DEC_BITS-1:0] word;
  logic [3:0]          nib;

  assign busy = (state != ST_IDLE);
  assign word = value[DEC_BITS-1:0];
  assign nib  = digits[idx*4 +: 4];

  // Hex mode: drop bits above the configured width and park the value in
  // the digit register, which the emit phase reads nibble by nibble
  always_comb begin
    hex_load = '0;
    hex_load[HEX_VALUE_WIDTH-1:0] = value[HEX_VALUE_WIDTH-1:0];
  end

  // Shared BCD step: one binary bit moves into the decimal digits per cycle
  itoa_dabble_step u_step (
    .bcd_in   (digits[BCD_BITS-1:0]),
    .shift_in (mag[DEC_BITS-1]),
    .bcd_out  (step_out)
  );

  always_comb begin
    digits_next = digits;
    digits_next[BCD_BITS-1:0] = step_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            started <= 1'b0;
            cnt     <= '0;
            if (operation) begin
              neg    <= 1'b0;
              digits <= hex_load;
              idx    <= IDX_W'(HEX_NIBBLES - 1);
              state  <= ST_EMIT;
            end else begin
              // Unsigned magnitude keeps the most negative value exact
              neg    <= word[DEC_BITS-1];
              mag    <= word[DEC_BITS-1] ? (~word + 1'b1) : word;
              digits <= '0;
              idx    <= IDX_W'(DEC_DIGITS - 1);
              state  <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          digits <= digits_next;
          mag    <= {mag[DEC_BITS-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(DEC_BITS - 1)) begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          // A negative magnitude is never zero, so the sign is never last
          strobe    <= 1'b1;
          character <= MINUS_CHAR;
          last      <= 1'b0;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          // Skip leading zeros without a beat; the units digit always goes out
          if (started || nib != 4'd0 || idx == '0) begin
            strobe    <= 1'b1;
            character <= digit_char(nib);
            last      <= (idx == '0);
            started   <= 1'b1;
          end
          if (idx == '0) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted command must take the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // More characters follow a non-final beat, so the run must still be active
  a_midrun_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("run ended before its last character");

  // The final beat is never followed at once by another beat
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("beat directly after final character");

  // The sign beat can only come from the decimal path, right before digits
  a_sign_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |=> (state == ST_EMIT && strobe && !last))
    else $error("sign beat out of sequence");

endmodule

// File: verif/integer_to_ascii_formatter_tb.sv
module integer_to_ascii_formatter_tb;
  import itoa_pkg::*;

  localparam int HEX_W          = HEX_VALUE_WIDTH_DEF;
  localparam int RANDOM_NUMBERS = 160;
  localparam int STALL_LIMIT    = 1000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES    = 64;    // longer than one decimal run

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // One number waiting to be sent, with the idle time that follows its run
  typedef struct {
    logic        operation;
    logic [63:0] value;
    int unsigned gap_after;
    bit          drain_first;
  } number_cmd_t;

  // One character the formatter owes us
  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [63:0] value;
  logic        strobe;
  logic [7:0]  character;
  logic        last;

  number_cmd_t number_queue[$];
  text_beat_t  expected_chars[$];
  number_cmd_t next_cmd;
  text_beat_t  exp_beat;

  logic        cmd_taken;
  int unsigned gap_left;
  int unsigned idle_run;
  int unsigned mismatch_count;
  int unsigned dec_numbers;
  int unsigned hex_numbers;
  int unsigned chars_checked;

  integer_to_ascii_formatter #(
    .HEX_VALUE_WIDTH(HEX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Build the text of one number, least significant character first, then
  // append it to the expected characters in printing order.
  function automatic void predict_text(input logic op, input logic [63:0] num);
    logic [7:0]  rev [0:15];
    logic [31:0] mag;
    logic [63:0] hex_val;
    logic [3:0]  nib;
    logic        neg;
    int          n;
    text_beat_t  beat;
    n = 0;
    if (op == OP_DEC) begin
      // Take the magnitude as unsigned so the most negative value stays exact
      neg = num[31];
      mag = neg ? (~num[31:0] + 32'd1) : num[31:0];
      do begin
        rev[n] = ZERO_CHAR + 8'(mag % DEC_RADIX);
        mag    = mag / DEC_RADIX;
        n++;
      end while (mag != 32'd0);
      if (neg) begin
        rev[n] = MINUS_CHAR;
        n++;
      end
    end else begin
      hex_val = num;
      if (HEX_W < 64) begin
        hex_val = num & ((64'd1 << HEX_W) - 64'd1);
      end
      do begin
        nib    = hex_val[3:0];
        rev[n] = (nib < DEC_RADIX) ? ZERO_CHAR + 8'(nib) : ALPHA_CHAR + 8'(nib - DEC_RADIX);
        hex_val = hex_val >> 4;
        n++;
      end while (hex_val != 64'd0);
    end
    for (int k = n - 1; k >= 0; k--) begin
      beat.character = rev[k];
      beat.last      = (k == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  task automatic queue_number(input logic op, input logic [63:0] num,
                              input int unsigned gap, input bit drain);
    number_cmd_t cmd;
    cmd.operation   = op;
    cmd.value       = num;
    cmd.gap_after   = gap;
    cmd.drain_first = drain;
    number_queue.push_back(cmd);
  endtask

  // Command driver: change inputs on the falling edge only. Hold a beat until
  // the monitor saw it taken, then either idle or present the next number.
  always @(negedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      operation <= OP_DEC;
      value     <= 64'd0;
      gap_left  <= 0;
    end else if (start && !cmd_taken) begin
      // hold the current beat
    end else if (number_queue.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left != 0) begin
      // idle burst counts only once the previous run has finished
      start <= 1'b0;
      if (!busy) begin
        gap_left <= gap_left - 1;
      end
    end else if (number_queue[0].drain_first && (expected_chars.size() != 0 || busy)) begin
      // hold off until every owed character has come out
      start <= 1'b0;
    end else begin
      next_cmd = number_queue.pop_front();
      start     <= 1'b1;
      operation <= next_cmd.operation;
      value     <= next_cmd.value;
      gap_left  <= next_cmd.gap_after;
    end
  end

  // Monitor: sample both channels on the rising edge. Check a character beat
  // against the oldest owed character first, then predict a newly taken
  // number, so the two never race within one edge.
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
      idle_run  <= 0;
    end else begin
      if (strobe === 1'b1) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character beat 0x%02h last=%0b with nothing owed",
                                    character, last));
        end else begin
          exp_beat = expected_chars.pop_front();
          if (character !== exp_beat.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      character, exp_beat.character));
          end
          if (last !== exp_beat.last) begin
            report_mismatch($sformatf("last %0b on character 0x%02h, expected %0b",
                                      last, character, exp_beat.last));
          end
          chars_checked++;
        end
      end
      if (start && busy === 1'b0) begin
        predict_text(operation, value);
        if (operation == OP_DEC) dec_numbers++;
        else hex_numbers++;
        cmd_taken <= 1'b1;
      end else begin
        cmd_taken <= 1'b0;
      end
      // advance the stall counter only when neither side moved a beat
      if (strobe === 1'b1 || (start && busy === 1'b0)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long
  initial begin
    wait (idle_run >= STALL_LIMIT);
    $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [63:0] num;
    logic [31:0] low_word;
    int unsigned gap;
    int unsigned kind;
    rst = 1'b1;

    // Directed numbers: zero, the decimal extremes, the most negative value,
    // digit-count boundaries, ignored upper bits, and hex extremes.
    queue_number(OP_DEC, 64'd0, 0, 1'b0);
    queue_number(OP_DEC, 64'd1, 3, 1'b0);
    queue_number(OP_DEC, 64'h0000_0000_FFFF_FFFF, 0, 1'b0);
    queue_number(OP_DEC, 64'h0000_0000_7FFF_FFFF, 1, 1'b0);
    queue_number(OP_DEC, 64'h0000_0000_8000_0000, 0, 1'b0);
    queue_number(OP_DEC, 64'd9, 0, 1'b0);
    queue_number(OP_DEC, 64'd10, 7, 1'b0);
    queue_number(OP_DEC, 64'h0000_0000_FFFF_FFF6, 0, 1'b0);
    queue_number(OP_DEC, 64'd1000000000, 0, 1'b1);
    queue_number(OP_DEC, 64'hDEAD_BEEF_0000_0000, 2, 1'b0);
    queue_number(OP_DEC, 64'hFFFF_FFFF_0000_007B, 0, 1'b0);
    queue_number(OP_DEC, 64'h5555_5555_AAAA_AAAA, 0, 1'b0);
    queue_number(OP_HEX, 64'd0, 0, 1'b0);
    queue_number(OP_HEX, 64'd1, 5, 1'b0);
    queue_number(OP_HEX, 64'hF, 0, 1'b0);
    queue_number(OP_HEX, 64'hA, 0, 1'b0);
    queue_number(OP_HEX, 64'h10, 0, 1'b1);
    queue_number(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    queue_number(OP_HEX, 64'h8000_0000_0000_0000, 4, 1'b0);
    queue_number(OP_HEX, 64'h0123_4567_89AB_CDEF, 0, 1'b0);
    queue_number(OP_HEX, 64'hFEDC_BA98_7654_3210, 0, 1'b0);
    queue_number(OP_HEX, 64'h0000_0000_FFFF_FFFF, 0, 1'b0);

    // Random numbers: a mix of full-width, truncated, tiny and small negative
    // values. Idle bursts follow some runs, except in a quiet stretch in the
    // middle and in the final stretch.
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      kind = $urandom_range(0, 3);
      num  = {$urandom, $urandom};
      case (kind)
        0: begin
          // keep the full random word
        end
        1: begin
          num = num >> $urandom_range(0, 63);
        end
        2: begin
          num = {$urandom, 32'($urandom_range(0, 20))};
          if ($urandom_range(0, 1)) num[63:32] = 32'd0;
        end
        default: begin
          low_word = 32'd0 - 32'($urandom_range(1, 1000));
          num      = {$urandom, low_word};
        end
      endcase
      if ((i >= 60 && i < 90) || i >= RANDOM_NUMBERS - 40) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 7) : 0;
      end
      queue_number(1'($urandom_range(0, 1)), num, gap,
                   (i % 37) == 36 && i < RANDOM_NUMBERS - 40);
    end

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every number is taken and every owed character has come
    while (number_queue.size() != 0 || start) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d decimal and %0d hex numbers, %0d characters checked",
             dec_numbers, hex_numbers, chars_checked);
    $display("Mismatches reported: %0d", mismatch_count);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
